// ===== hw/rtl/tensor_axis_difference_macros.svh =====
// Assertion macros used by the tensor_axis_difference checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef TENSOR_AXIS_DIFFERENCE_MACROS_SVH
`define TENSOR_AXIS_DIFFERENCE_MACROS_SVH

// check cons in the same cycle as ante
`define TAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define TAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tad_pkg.sv =====
// Shared types, sizes and helpers of the tensor axis difference block.
// No dependencies; used by every module of the block but tad_hist_ram.
package tad_pkg;

	localparam int unsigned MAX_OUTER  = 64;
	localparam int unsigned MAX_MIDDLE = 64;
	localparam int unsigned MAX_INNER  = 64;

	localparam int unsigned OUTER_W  = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
	localparam int unsigned MIDDLE_W = (MAX_MIDDLE > 1) ? $clog2(MAX_MIDDLE) : 1;
	localparam int unsigned INNER_W  = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

	localparam int unsigned HIST_DEPTH = MAX_MIDDLE * MAX_INNER;
	localparam int unsigned HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned DIFF_W  = DATA_W + 1;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned PROD_W  = DIFF_W + FRAC_W + 1;
	localparam int unsigned SUM_W   = PROD_W + 1;
	localparam int unsigned SIZE_W  = 7;
	localparam int unsigned AXIS_W  = 2;
	localparam int unsigned INDEX_W = 3;

	localparam int unsigned PIPE_DEPTH = 4;

	localparam int unsigned LEN_O = $clog2(MAX_OUTER + 1);
	localparam int unsigned LEN_M = $clog2(MAX_MIDDLE + 1);
	localparam int unsigned LEN_I = $clog2(MAX_INNER + 1);
	localparam int unsigned LEN_OM = (LEN_O > LEN_M) ? LEN_O : LEN_M;
	localparam int unsigned LEN_OMI = (LEN_OM > LEN_I) ? LEN_OM : LEN_I;
	localparam int unsigned LEN_W = (LEN_OMI > SIZE_W) ? LEN_OMI : SIZE_W;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
	localparam logic [DATA_W-1:0] INV_RESET  = DATA_W'(32'h0001_0000);

	typedef enum logic [AXIS_W-1:0] {
		AXIS_OUTER  = 2'd0,
		AXIS_MIDDLE = 2'd1,
		AXIS_INNER  = 2'd2
	} axis_t;

	typedef enum logic [INDEX_W-1:0] {
		REG_AXIS         = 3'd0,
		REG_SIZE_OUTER   = 3'd1,
		REG_SIZE_MIDDLE  = 3'd2,
		REG_SIZE_INNER   = 3'd3,
		REG_INV_OUTER    = 3'd4,
		REG_INV_MIDDLE   = 3'd5,
		REG_INV_INNER    = 3'd6
	} reg_index_t;

	typedef struct packed {
		axis_t             axis;
		logic [SIZE_W-1:0] size_outer;
		logic [SIZE_W-1:0] size_middle;
		logic [SIZE_W-1:0] size_inner;
		logic [DATA_W-1:0] inv_outer;
		logic [DATA_W-1:0] inv_middle;
		logic [DATA_W-1:0] inv_inner;
	} cfg_t;

	typedef struct packed {
		logic              zero;
		logic              done;
		logic [DATA_W-1:0] inv;
	} ctrl_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [SIZE_W-1:0] s,
			input logic [LEN_W-1:0] lim);
		logic [LEN_W-1:0] v;
		v = LEN_W'(s);
		if (s == '0) begin
			eff_len = LEN_W'(1);
		end else if (v > lim) begin
			eff_len = lim;
		end else begin
			eff_len = v;
		end
	endfunction

endpackage

// ===== hw/rtl/tad_hist_ram.sv =====
// Generic single-clock RAM, one write and one registered read port, read-first.
// No dependencies.
module tad_hist_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned WIDTH = 32
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/tad_addr_gen.sv =====
// Position counters and history addressing of the tensor axis difference block.
// Depends on tad_pkg.
module tad_addr_gen (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  tad_pkg::cfg_t                 cfg,
	output logic [tad_pkg::HIST_AW-1:0]   wr_addr,
	output logic [tad_pkg::HIST_AW-1:0]   rd_addr,
	output tad_pkg::ctrl_t                ctrl
);

	logic [tad_pkg::OUTER_W-1:0]  pos_outer_q;
	logic [tad_pkg::MIDDLE_W-1:0] pos_middle_q;
	logic [tad_pkg::INNER_W-1:0]  pos_inner_q;
	logic                         last_outer;
	logic                         last_middle;
	logic                         last_inner;

	assign last_outer = (tad_pkg::LEN_W'(pos_outer_q) + tad_pkg::LEN_W'(1)) >=
		tad_pkg::eff_len(cfg.size_outer, tad_pkg::LEN_W'(tad_pkg::MAX_OUTER));
	assign last_middle = (tad_pkg::LEN_W'(pos_middle_q) + tad_pkg::LEN_W'(1)) >=
		tad_pkg::eff_len(cfg.size_middle, tad_pkg::LEN_W'(tad_pkg::MAX_MIDDLE));
	assign last_inner = (tad_pkg::LEN_W'(pos_inner_q) + tad_pkg::LEN_W'(1)) >=
		tad_pkg::eff_len(cfg.size_inner, tad_pkg::LEN_W'(tad_pkg::MAX_INNER));

	assign wr_addr = tad_pkg::HIST_AW'(pos_middle_q) * tad_pkg::HIST_AW'(tad_pkg::MAX_INNER)
		+ tad_pkg::HIST_AW'(pos_inner_q);

	always_comb begin
		ctrl.done = last_inner & last_middle & last_outer;
		case (cfg.axis)
			tad_pkg::AXIS_OUTER: begin
				rd_addr   = wr_addr;
				ctrl.zero = (pos_outer_q == '0);
				ctrl.inv  = cfg.inv_outer;
			end
			tad_pkg::AXIS_MIDDLE: begin
				rd_addr   = wr_addr - tad_pkg::HIST_AW'(tad_pkg::MAX_INNER);
				ctrl.zero = (pos_middle_q == '0);
				ctrl.inv  = cfg.inv_middle;
			end
			default: begin
				rd_addr   = wr_addr - tad_pkg::HIST_AW'(1);
				ctrl.zero = (pos_inner_q == '0);
				ctrl.inv  = cfg.inv_inner;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_outer_q  <= '0;
			pos_middle_q <= '0;
			pos_inner_q  <= '0;
		end else if (advance) begin
			if (last_inner) begin
				pos_inner_q <= '0;
				if (last_middle) begin
					pos_middle_q <= '0;
					if (last_outer) begin
						pos_outer_q <= '0;
					end else begin
						pos_outer_q <= pos_outer_q + 1'b1;
					end
				end else begin
					pos_middle_q <= pos_middle_q + 1'b1;
				end
			end else begin
				pos_inner_q <= pos_inner_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/tad_scale_pipe.sv =====
// Subtract, scale and saturate pipeline with per-stage flow control.
// Depends on tad_pkg; takes the registered history read data in the cycle after a transfer.
module tad_scale_pipe (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	output logic                                 load_ready,
	input  logic signed [tad_pkg::DATA_W-1:0]    sample,
	input  tad_pkg::ctrl_t                       ctrl,
	input  logic [tad_pkg::DATA_W-1:0]           prev,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [tad_pkg::DATA_W-1:0]    slope,
	output logic                                 tensor_done
);

	localparam int unsigned HALF_W = tad_pkg::FRAC_W;

	logic                                  valid_s1;
	logic signed [tad_pkg::DATA_W-1:0]     sample_s1;
	tad_pkg::ctrl_t                        ctrl_s1;

	logic                                  valid_s2;
	logic signed [tad_pkg::DIFF_W-1:0]     diff_s2;
	logic [tad_pkg::DATA_W-1:0]            inv_s2;
	logic                                  done_s2;

	logic                                  valid_s3;
	logic signed [tad_pkg::PROD_W-1:0]     p_hi_s3;
	logic signed [tad_pkg::PROD_W-1:0]     p_lo_s3;
	logic                                  done_s3;

	logic                                  valid_q;
	logic signed [tad_pkg::DATA_W-1:0]     slope_q;
	logic                                  done_q;

	logic                                  en_s2;
	logic                                  en_s3;
	logic                                  en_out;

	logic signed [tad_pkg::DIFF_W-1:0]     diff;
	logic signed [HALF_W:0]                inv_hi;
	logic signed [HALF_W:0]                inv_lo;
	logic signed [tad_pkg::PROD_W-1:0]     p_hi;
	logic signed [tad_pkg::PROD_W-1:0]     p_lo;
	logic signed [tad_pkg::SUM_W-1:0]      sum;
	logic signed [tad_pkg::DATA_W-1:0]     sat;

	assign en_out     = !valid_q || out_ready;
	assign en_s3      = !valid_s3 || en_out;
	assign en_s2      = !valid_s2 || en_s3;
	assign load_ready = !valid_s1 || en_s2;

	assign diff = ctrl_s1.zero ? '0 :
		($signed({sample_s1[tad_pkg::DATA_W-1], sample_s1}) -
		 $signed({prev[tad_pkg::DATA_W-1], prev}));

	assign inv_hi = $signed({1'b0, inv_s2[tad_pkg::DATA_W-1:HALF_W]});
	assign inv_lo = $signed({1'b0, inv_s2[HALF_W-1:0]});
	assign p_hi   = diff_s2 * inv_hi;
	assign p_lo   = diff_s2 * inv_lo;

	assign sum = tad_pkg::SUM_W'(p_hi_s3) + tad_pkg::SUM_W'(p_lo_s3 >>> tad_pkg::FRAC_W);

	always_comb begin
		if (!sum[tad_pkg::SUM_W-1] && (|sum[tad_pkg::SUM_W-2:tad_pkg::DATA_W-1])) begin
			sat = $signed({1'b0, {(tad_pkg::DATA_W-1){1'b1}}});
		end else if (sum[tad_pkg::SUM_W-1] && !(&sum[tad_pkg::SUM_W-2:tad_pkg::DATA_W-1])) begin
			sat = $signed({1'b1, {(tad_pkg::DATA_W-1){1'b0}}});
		end else begin
			sat = sum[tad_pkg::DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load_ready) begin
				valid_s1 <= load;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_out) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ready) begin
			sample_s1 <= sample;
			ctrl_s1   <= ctrl;
		end
		if (en_s2) begin
			diff_s2 <= diff;
			inv_s2  <= ctrl_s1.inv;
			done_s2 <= ctrl_s1.done;
		end
		if (en_s3) begin
			p_hi_s3 <= p_hi;
			p_lo_s3 <= p_lo;
			done_s3 <= done_s2;
		end
		if (en_out) begin
			slope_q <= sat;
			done_q  <= done_s3;
		end
	end

	assign out_valid   = valid_q;
	assign slope       = slope_q;
	assign tensor_done = done_q;

endmodule

// ===== hw/rtl/tensor_axis_difference.sv =====
// Top level of the tensor axis difference block: configuration registers,
// history RAM, address generator and scale pipeline. Depends on tad_pkg.
//
// Streams a 3-D tensor of signed Q16.16 samples (inner index fastest) and
// returns, per sample, the backward difference along the selected axis times
// the matching reciprocal spacing, floored to Q16.16 and saturated to 32 bits;
// the slope is zero where the index on that axis is 0, and tensor_done marks
// the last sample of each tensor. One sample is taken every clock while the
// output is not stalled; a slope passes through the s1, s2, s3 and output
// registers after its sample transfer. The rate is set by the history
// RAM, which takes one read and one write per sample, the write going to the
// current (row, column) entry and the read returning the old contents before
// the write. The RAM needs no clearing after reset. Write the registers only
// while no result is outstanding.
module tensor_axis_difference (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tad_pkg::INDEX_W-1:0]           cfg_index,
	input  logic [tad_pkg::DATA_W-1:0]            cfg_data,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [tad_pkg::DATA_W-1:0]     sample,
	output logic                                  slope_valid,
	input  logic                                  slope_ready,
	output logic signed [tad_pkg::DATA_W-1:0]     slope,
	output logic                                  tensor_done
);

	tad_pkg::cfg_t                  cfg_q;
	tad_pkg::ctrl_t                 ctrl;
	logic                           accept;
	logic [tad_pkg::HIST_AW-1:0]    wr_addr;
	logic [tad_pkg::HIST_AW-1:0]    rd_addr;
	logic [tad_pkg::DATA_W-1:0]     prev;

	assign cfg_ready = 1'b1;
	assign accept    = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis        <= tad_pkg::AXIS_OUTER;
			cfg_q.size_outer  <= tad_pkg::SIZE_RESET;
			cfg_q.size_middle <= tad_pkg::SIZE_RESET;
			cfg_q.size_inner  <= tad_pkg::SIZE_RESET;
			cfg_q.inv_outer   <= tad_pkg::INV_RESET;
			cfg_q.inv_middle  <= tad_pkg::INV_RESET;
			cfg_q.inv_inner   <= tad_pkg::INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (tad_pkg::reg_index_t'(cfg_index))
				tad_pkg::REG_AXIS: begin
					cfg_q.axis <= tad_pkg::axis_t'(cfg_data[tad_pkg::AXIS_W-1:0]);
				end
				tad_pkg::REG_SIZE_OUTER: begin
					cfg_q.size_outer <= cfg_data[tad_pkg::SIZE_W-1:0];
				end
				tad_pkg::REG_SIZE_MIDDLE: begin
					cfg_q.size_middle <= cfg_data[tad_pkg::SIZE_W-1:0];
				end
				tad_pkg::REG_SIZE_INNER: begin
					cfg_q.size_inner <= cfg_data[tad_pkg::SIZE_W-1:0];
				end
				tad_pkg::REG_INV_OUTER: begin
					cfg_q.inv_outer <= cfg_data;
				end
				tad_pkg::REG_INV_MIDDLE: begin
					cfg_q.inv_middle <= cfg_data;
				end
				tad_pkg::REG_INV_INNER: begin
					cfg_q.inv_inner <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	tad_addr_gen u_addr_gen (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.cfg     (cfg_q),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.ctrl    (ctrl)
	);

	tad_hist_ram #(
		.DEPTH (tad_pkg::HIST_DEPTH),
		.WIDTH (tad_pkg::DATA_W)
	) u_hist_ram (
		.clk     (clk),
		.we      (accept),
		.waddr   (wr_addr),
		.wdata   (sample),
		.re      (accept),
		.raddr   (rd_addr),
		.rdata_q (prev)
	);

	tad_scale_pipe u_scale_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (sample_valid),
		.load_ready  (sample_ready),
		.sample      (sample),
		.ctrl        (ctrl),
		.prev        (prev),
		.out_valid   (slope_valid),
		.out_ready   (slope_ready),
		.slope       (slope),
		.tensor_done (tensor_done)
	);

endmodule

// ===== hw/rtl/tad_checker.sv =====
// Port-level checks of tensor_axis_difference, bound to the top level.
// Depends on tad_pkg and tensor_axis_difference_macros.svh.
`include "tensor_axis_difference_macros.svh"

module tad_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_ready,
	input logic                               slope_valid,
	input logic                               slope_ready,
	input logic signed [tad_pkg::DATA_W-1:0]  slope,
	input logic                               tensor_done
);

	localparam int unsigned CNT_W = $clog2(tad_pkg::PIPE_DEPTH + 1);

	logic [CNT_W-1:0] inflight_q;
	logic             in_xfer;
	logic             out_xfer;

	assign in_xfer  = sample_valid && sample_ready;
	assign out_xfer = slope_valid && slope_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`TAD_ASSERT_NEXT(a_out_hold, slope_valid && !slope_ready, slope_valid && $stable(slope) && $stable(tensor_done), "stalled result changed")
	`TAD_ASSERT_NOW(a_ready_when_empty, !slope_valid, sample_ready, "input stalled with empty output")
	`TAD_ASSERT_NOW(a_depth, 1'b1, inflight_q <= CNT_W'(tad_pkg::PIPE_DEPTH), "too many items held")
	`TAD_ASSERT_NOW(a_no_invented, slope_valid, inflight_q != '0, "result without a sample")

endmodule

bind tensor_axis_difference tad_checker u_tad_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.slope_valid  (slope_valid),
	.slope_ready  (slope_ready),
	.slope        (slope),
	.tensor_done  (tensor_done)
);

// ===== sim/tensor_axis_difference_test.sv =====
// Self-checking test of tensor_axis_difference: streams whole tensors under
// changing axis, size and spacing settings and checks every slope. Depends on tad_pkg.
module tensor_axis_difference_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_SAMPLES = 950;
	localparam int unsigned CYCLE_LIMIT    = 400000;

	typedef struct packed {
		logic [tad_pkg::DATA_W-1:0] slope;
		logic                       done;
	} slope_item_t;

	class slope_scoreboard;
		logic [tad_pkg::AXIS_W-1:0] axis;
		logic [tad_pkg::SIZE_W-1:0] len_outer, len_middle, len_inner;
		logic [tad_pkg::DATA_W-1:0] recip_outer, recip_middle, recip_inner;
		int unsigned                at_outer, at_middle, at_inner;
		logic [tad_pkg::DATA_W-1:0] plane_mem [tad_pkg::HIST_DEPTH];
		slope_item_t                pending [$];
		int unsigned                accepted, checked, failures, tensors, clipped, zeroed;

		function new();
			axis = tad_pkg::AXIS_OUTER;
			len_outer = tad_pkg::SIZE_RESET;
			len_middle = tad_pkg::SIZE_RESET;
			len_inner = tad_pkg::SIZE_RESET;
			recip_outer = tad_pkg::INV_RESET;
			recip_middle = tad_pkg::INV_RESET;
			recip_inner = tad_pkg::INV_RESET;
			at_outer = 0;
			at_middle = 0;
			at_inner = 0;
		endfunction

		function void set_reg(tad_pkg::reg_index_t idx, logic [tad_pkg::DATA_W-1:0] val);
			case (idx)
				tad_pkg::REG_AXIS:        axis = val[tad_pkg::AXIS_W-1:0];
				tad_pkg::REG_SIZE_OUTER:  len_outer = val[tad_pkg::SIZE_W-1:0];
				tad_pkg::REG_SIZE_MIDDLE: len_middle = val[tad_pkg::SIZE_W-1:0];
				tad_pkg::REG_SIZE_INNER:  len_inner = val[tad_pkg::SIZE_W-1:0];
				tad_pkg::REG_INV_OUTER:   recip_outer = val;
				tad_pkg::REG_INV_MIDDLE:  recip_middle = val;
				tad_pkg::REG_INV_INNER:   recip_inner = val;
				default: ;
			endcase
		endfunction

		function int unsigned span(logic [tad_pkg::SIZE_W-1:0] s, int unsigned lim);
			if (s == '0) return 1;
			if (s > lim) return lim;
			return s;
		endfunction

		// floor((cur - prev) * recip / 2^16), clipped to 32 bits
		function logic [tad_pkg::DATA_W-1:0] scaled_diff(
				logic signed [tad_pkg::DATA_W-1:0] cur,
				logic signed [tad_pkg::DATA_W-1:0] prev,
				logic [tad_pkg::DATA_W-1:0] recip);
			logic signed [66:0] a, b, m, q;
			a = cur;
			b = prev;
			m = {35'd0, recip};
			q = ((a - b) * m) >>> 16;
			if (q > 67'sd2147483647) begin
				clipped++;
				return 32'h7FFF_FFFF;
			end else if (q < -67'sd2147483648) begin
				clipped++;
				return 32'h8000_0000;
			end
			return q[tad_pkg::DATA_W-1:0];
		endfunction

		function void note_sample(logic [tad_pkg::DATA_W-1:0] raw);
			int unsigned so, sm, si, j, k, addr;
			slope_item_t want;
			so = span(len_outer, tad_pkg::MAX_OUTER);
			sm = span(len_middle, tad_pkg::MAX_MIDDLE);
			si = span(len_inner, tad_pkg::MAX_INNER);
			j = (at_middle < tad_pkg::MAX_MIDDLE) ? at_middle : tad_pkg::MAX_MIDDLE - 1;
			k = (at_inner < tad_pkg::MAX_INNER) ? at_inner : tad_pkg::MAX_INNER - 1;
			addr = j * tad_pkg::MAX_INNER + k;
			want.slope = '0;
			case (axis)
				tad_pkg::AXIS_OUTER: begin
					if (at_outer != 0)
						want.slope = scaled_diff(raw, plane_mem[addr], recip_outer);
					else
						zeroed++;
				end
				tad_pkg::AXIS_MIDDLE: begin
					if (j != 0)
						want.slope = scaled_diff(raw,
							plane_mem[addr - tad_pkg::MAX_INNER], recip_middle);
					else
						zeroed++;
				end
				default: begin
					if (k != 0)
						want.slope = scaled_diff(raw, plane_mem[addr - 1], recip_inner);
					else
						zeroed++;
				end
			endcase
			plane_mem[addr] = raw;
			want.done = 1'b0;
			if (at_inner + 1 >= si) begin
				at_inner = 0;
				if (at_middle + 1 >= sm) begin
					at_middle = 0;
					if (at_outer + 1 >= so) begin
						at_outer = 0;
						want.done = 1'b1;
					end else begin
						at_outer++;
					end
				end else begin
					at_middle++;
				end
			end else begin
				at_inner++;
			end
			pending = {pending, want};
			accepted++;
		endfunction

		function bit at_start();
			return at_outer == 0 && at_middle == 0 && at_inner == 0;
		endfunction

		task report(string what, logic [tad_pkg::DATA_W-1:0] got,
				logic [tad_pkg::DATA_W-1:0] want);
			failures++;
			$display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
		endtask

		task check_slope(logic [tad_pkg::DATA_W-1:0] got_slope, logic got_done);
			slope_item_t want;
			if (pending.size() == 0) begin
				report("slope with nothing pending", got_slope, '0);
				return;
			end
			want = pending.pop_front();
			if (got_slope !== want.slope)
				report("slope", got_slope, want.slope);
			if (got_done !== want.done)
				report("tensor_done", {31'd0, got_done}, {31'd0, want.done});
			if (want.done)
				tensors++;
			checked++;
		endtask
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [tad_pkg::INDEX_W-1:0]       cfg_index;
	logic [tad_pkg::DATA_W-1:0]        cfg_data;
	logic                              sample_valid;
	logic                              sample_ready;
	logic signed [tad_pkg::DATA_W-1:0] sample;
	logic                              slope_valid;
	logic                              slope_ready;
	logic signed [tad_pkg::DATA_W-1:0] slope;
	logic                              tensor_done;

	slope_scoreboard sb;
	int unsigned     idle_pct, stall_pct, cycles, reg_writes;
	logic [tad_pkg::DATA_W-1:0] last_value;

	tensor_axis_difference u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.slope_valid  (slope_valid),
		.slope_ready  (slope_ready),
		.slope        (slope),
		.tensor_done  (tensor_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d slopes pending", cycles,
				sb.pending.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (slope_valid && slope_ready)
				sb.check_slope(slope, tensor_done);
			slope_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic cfg_write(input tad_pkg::reg_index_t idx,
			input logic [tad_pkg::DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic send_sample(input logic [tad_pkg::DATA_W-1:0] val);
		int unsigned gap;
		case ((sb.accepted / 200) % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 55; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 55; end
			default: begin idle_pct = 23; stall_pct = 23; end
		endcase
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= val;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		sb.note_sample(val);
		last_value = val;
	endtask

	// drop valid and hold until every slope is back
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (tad_pkg::PIPE_DEPTH + 2) @(posedge clk);
	endtask

	function automatic logic [tad_pkg::DATA_W-1:0] next_value();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (r < 5)
			return $urandom;
		return last_value + $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
	endfunction

	function automatic logic [tad_pkg::DATA_W-1:0] next_recip();
		case ($urandom_range(0, 4))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h4_0000);
		endcase
	endfunction

	function automatic logic [tad_pkg::SIZE_W-1:0] long_size();
		case ($urandom_range(0, 3))
			0: return tad_pkg::SIZE_W'(64);
			1: return tad_pkg::SIZE_W'(127);
			2: return tad_pkg::SIZE_W'($urandom_range(65, 126));
			default: return tad_pkg::SIZE_W'($urandom_range(33, 63));
		endcase
	endfunction

	// one axis may run long only while the other two stay at 2 or less
	task automatic pick_config();
		int unsigned long_axis;
		logic [tad_pkg::SIZE_W-1:0] so, sm, si;
		long_axis = $urandom_range(0, 5);
		so = tad_pkg::SIZE_W'($urandom_range(0, (long_axis < 3) ? 2 : 6));
		sm = tad_pkg::SIZE_W'($urandom_range(0, (long_axis < 3) ? 2 : 6));
		si = tad_pkg::SIZE_W'($urandom_range(0, (long_axis < 3) ? 2 : 6));
		case (long_axis)
			0: so = long_size();
			1: sm = long_size();
			2: si = long_size();
			default: ;
		endcase
		cfg_write(tad_pkg::REG_AXIS, $urandom_range(0, 3));
		cfg_write(tad_pkg::REG_SIZE_OUTER, so);
		cfg_write(tad_pkg::REG_SIZE_MIDDLE, sm);
		cfg_write(tad_pkg::REG_SIZE_INNER, si);
		if ($urandom_range(0, 4) < 3)
			cfg_write(tad_pkg::REG_INV_OUTER, next_recip());
		if ($urandom_range(0, 4) < 3)
			cfg_write(tad_pkg::REG_INV_MIDDLE, next_recip());
		if ($urandom_range(0, 4) < 3)
			cfg_write(tad_pkg::REG_INV_INNER, next_recip());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = tad_pkg::REG_AXIS;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample = '0;
		slope_ready = 1'b0;
		cycles = 0;
		reg_writes = 0;
		idle_pct = 0;
		stall_pct = 0;
		last_value = '0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rails and saturation along the inner axis
		cfg_write(tad_pkg::REG_AXIS, tad_pkg::AXIS_INNER);
		cfg_write(tad_pkg::REG_SIZE_OUTER, 1);
		cfg_write(tad_pkg::REG_SIZE_MIDDLE, 1);
		cfg_write(tad_pkg::REG_SIZE_INNER, 8);
		cfg_write(tad_pkg::REG_INV_INNER, 32'h0001_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0001);
		send_sample(32'h0001_0000);
		send_sample(32'h0000_8000);
		drain();

		// largest reciprocal on the outer axis, floor on negatives
		cfg_write(tad_pkg::REG_AXIS, tad_pkg::AXIS_OUTER);
		cfg_write(tad_pkg::REG_SIZE_OUTER, 2);
		cfg_write(tad_pkg::REG_SIZE_INNER, 3);
		cfg_write(tad_pkg::REG_INV_OUTER, 32'hFFFF_FFFF);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0005);
		send_sample(32'h0000_0001);
		send_sample(32'hFFFF_FFFF);
		send_sample(32'h0000_0005);
		drain();

		// reciprocal spacing of one half on the middle axis
		cfg_write(tad_pkg::REG_AXIS, tad_pkg::AXIS_MIDDLE);
		cfg_write(tad_pkg::REG_SIZE_OUTER, 1);
		cfg_write(tad_pkg::REG_SIZE_MIDDLE, 3);
		cfg_write(tad_pkg::REG_SIZE_INNER, 2);
		cfg_write(tad_pkg::REG_INV_MIDDLE, 32'h0000_8000);
		send_sample(32'h0000_0003);
		send_sample(32'hFFFF_FFFC);
		send_sample(32'h0000_0004);
		send_sample(32'hFFFF_FFF9);
		send_sample(32'h0000_0008);
		send_sample(32'h7FFF_FFFF);
		drain();

		// selector 3 acts as inner, inner size 0 acts as 1
		cfg_write(tad_pkg::REG_AXIS, 3);
		cfg_write(tad_pkg::REG_SIZE_OUTER, 2);
		cfg_write(tad_pkg::REG_SIZE_MIDDLE, 2);
		cfg_write(tad_pkg::REG_SIZE_INNER, 0);
		repeat (4) send_sample($urandom);
		drain();

		// shrink the rows part way through a tensor
		cfg_write(tad_pkg::REG_AXIS, tad_pkg::AXIS_INNER);
		cfg_write(tad_pkg::REG_SIZE_MIDDLE, 4);
		cfg_write(tad_pkg::REG_SIZE_INNER, 8);
		repeat (13) send_sample(next_value());
		drain();
		cfg_write(tad_pkg::REG_SIZE_INNER, 3);
		do
			send_sample(next_value());
		while (!sb.at_start());

		while (sb.accepted < RANDOM_SAMPLES) begin
			if ($urandom_range(0, 1) == 0) begin
				drain();
				pick_config();
			end
			do begin
				send_sample(next_value());
				if ($urandom_range(0, 299) == 0)
					drain();
			end while (!sb.at_start());
		end
		drain();

		if (sb.pending.size() != 0)
			sb.report("slopes never returned", sb.pending.size(), '0);
		$display("%0d samples in %0d tensors, %0d slopes checked, %0d register writes",
			sb.accepted, sb.tensors, sb.checked, reg_writes);
		$display("%0d clipped slopes, %0d slopes at index zero, %0d cycles",
			sb.clipped, sb.zeroed, cycles);
		if (sb.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
